@@ rtl/core/pbdfr_pkg.sv @@
package pbdfr_pkg;

   // first bytes of a frame kept for decoding
   localparam int HEAD_DEPTH = 24;
   localparam int HEAD_IDX_W = 5;

   // result codes
   localparam logic [3:0] KIND_PUMP_STATUS  = 4'd0;
   localparam logic [3:0] KIND_PUMP_OTHER   = 4'd1;
   localparam logic [3:0] KIND_PUMP_SUM_BAD = 4'd2;
   localparam logic [3:0] KIND_TEMP         = 4'd3;
   localparam logic [3:0] KIND_SALT         = 4'd4;
   localparam logic [3:0] KIND_TAKEOVER     = 4'd5;
   localparam logic [3:0] KIND_VERSION      = 4'd6;
   localparam logic [3:0] KIND_CHLOR_OTHER  = 4'd7;
   localparam logic [3:0] KIND_CHLOR_OVFL   = 4'd8;
   localparam logic [3:0] KIND_PUMP_LONG    = 4'd9;

   // pump framing bytes
   localparam logic [7:0] PUMP_SYNC     = 8'hFF;
   localparam logic [7:0] PUMP_ZERO     = 8'h00;
   localparam logic [7:0] PUMP_LEAD     = 8'hA5;
   localparam logic [7:0] PUMP_SRC      = 8'h60;
   localparam logic [7:0] PUMP_CMD_STAT = 8'h07;
   localparam logic [7:0] STATUS_MIN_LEN = 8'd15;

   // chlorinator framing bytes and commands
   localparam logic [7:0] CHLOR_DLE      = 8'h10;
   localparam logic [7:0] CHLOR_STX      = 8'h02;
   localparam logic [7:0] CHLOR_ETX      = 8'h03;
   localparam logic [7:0] CMD_VERSION    = 8'h03;
   localparam logic [7:0] CMD_TEMP       = 8'h16;
   localparam logic [7:0] CMD_SALT       = 8'h12;
   localparam logic [7:0] CMD_TAKEOVER   = 8'h01;

   // scale factors
   localparam logic [13:0] SALT_SCALE   = 14'd50;
   localparam logic [13:0] MIN_PER_HOUR = 14'd60;

   typedef struct packed {
      logic [3:0]  frame_kind;
      logic [7:0]  water_temperature;
      logic [13:0] salt_ppm;
      logic [7:0]  fault_flags;
      logic [7:0]  run_code;
      logic [7:0]  program_code;
      logic [15:0] power_watts;
      logic [15:0] speed_rpm;
      logic [7:0]  flow_raw;
      logic [7:0]  pressure_raw;
      logic [13:0] time_left_minutes;
      logic [13:0] clock_minutes;
   } result_type;

endpackage

@@ rtl/core/pool_bus_dual_frame_receiver.sv @@
// Pool bus frame receiver for pump and chlorinator packets.
// Input channel (req_): one received bus byte per item on req_rx_byte.
// Result channel (rsp_): one item per completed or rejected frame, with
// rsp_frame_kind telling the frame type and the decoded fields beside it;
// fields that mean nothing for the kind are zero.
// Bytes that do not end a frame give no result item.
// A byte accepted into the input register is framed when the framer advances,
// and its result is loaded into the result register and shown on rsp_.
// Throughput: one byte per cycle unless a frame end waits on a held result;
// the single framing stage between input and result registers sets this rate.
// When the receiver stalls, the result register holds its item; the input
// register still takes one more byte, and bytes that make no result keep
// flowing through the framer. Only a byte that ends a frame waits.
// Reset clears the framer to idle, drops any queued byte and result, and
// clears the running sum, count, length and previous byte. The captured
// header bytes are not cleared.
module pool_bus_dual_frame_receiver
   import pbdfr_pkg::*;
#(
   parameter int CHLOR_MAX_BYTES  = 64,
   parameter int PUMP_MAX_PAYLOAD = 255
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_frame_kind,
   output logic [7:0]  rsp_water_temperature,
   output logic [13:0] rsp_salt_ppm,
   output logic [7:0]  rsp_fault_flags,
   output logic [7:0]  rsp_run_code,
   output logic [7:0]  rsp_program_code,
   output logic [15:0] rsp_power_watts,
   output logic [15:0] rsp_speed_rpm,
   output logic [7:0]  rsp_flow_raw,
   output logic [7:0]  rsp_pressure_raw,
   output logic [13:0] rsp_time_left_minutes,
   output logic [13:0] rsp_clock_minutes
);

   // framer state codes
   localparam logic [1:0] FT_IDLE  = 2'd0;
   localparam logic [1:0] FT_PUMP  = 2'd1;
   localparam logic [1:0] FT_CHLOR = 2'd2;

   localparam logic [8:0] PUMP_MAX_W  = 9'(PUMP_MAX_PAYLOAD);
   localparam logic [9:0] CHLOR_MAX_W = 10'(CHLOR_MAX_BYTES);

   logic        byte_vld_ff, byte_vld_in;
   logic [7:0]  byte_ff;
   logic [1:0]  type_ff, type_in;
   logic [8:0]  count_ff, count_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  prev_ff, prev_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  head_ff [HEAD_DEPTH];
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  res_ff, res_in;

   logic                  head_we;
   logic [HEAD_IDX_W-1:0] head_idx;
   logic                  res_hit;
   logic                  adv;
   logic                  req_take;

   // input handshake
   assign req_take    = req_valid && !req_stall;
   assign adv         = byte_vld_ff && (!res_hit || !rsp_valid_ff || !rsp_stall);
   assign req_stall   = byte_vld_ff && !adv;
   assign byte_vld_in = req_take ? 1'b1 : (adv ? 1'b0 : byte_vld_ff);

   // result handshake
   assign rsp_valid_in = (adv && res_hit) || (rsp_valid_ff && rsp_stall);

   // framing logic for the byte in the input register
   always_comb begin
      logic [8:0]  n;
      logic [7:0]  b;
      logic [8:0]  len_w;
      logic [7:0]  hv4;
      logic [7:0]  hv5;
      logic        hdr_bad;
      logic        chl_end;
      n       = count_ff;
      b       = byte_ff;
      len_w   = {1'b0, len_ff};
      hv4     = (n == 9'd4) ? b : head_ff[4];
      hv5     = (n == 9'd5) ? b : head_ff[5];
      hdr_bad = (n == 9'd1 && b != PUMP_ZERO) || (n == 9'd2 && b != PUMP_SYNC) ||
                (n == 9'd3 && b != PUMP_LEAD);
      chl_end = (n >= 9'd3) && (b == CHLOR_ETX) && (prev_ff == CHLOR_DLE) &&
                (head_ff[1] == CHLOR_STX);

      type_in  = type_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      prev_in  = prev_ff;
      len_in   = len_ff;
      head_we  = 1'b0;
      head_idx = n[HEAD_IDX_W-1:0];
      res_hit  = 1'b0;
      res_in   = '0;

      if (type_ff == FT_IDLE) begin
         // wait for a start byte
         if (b == PUMP_SYNC || b == CHLOR_DLE) begin
            type_in  = (b == PUMP_SYNC) ? FT_PUMP : FT_CHLOR;
            head_we  = 1'b1;
            head_idx = '0;
            count_in = 9'd1;
            sum_in   = '0;
            prev_in  = b;
            len_in   = '0;
         end
      end else begin
         head_we  = (n < 9'(HEAD_DEPTH));
         count_in = n + 9'd1;
         if (type_ff == FT_PUMP) begin
            if (hdr_bad) begin
               type_in  = FT_IDLE;
               count_in = '0;
            end else begin
               // checksum covers the lead byte through the payload
               if (n >= 9'd3 && (n <= 9'd8 || n <= len_w + 9'd8)) begin
                  sum_in = sum_ff + 16'(b);
               end
               if (n == 9'd8) begin
                  len_in = b;
               end
               if (n == 9'd8 && {1'b0, b} > PUMP_MAX_W) begin
                  res_hit = 1'b1;
                  res_in.frame_kind = KIND_PUMP_LONG;
               end else if (n <= 9'd8 || n < len_w + 9'd10) begin
                  prev_in = b;
               end else if ({prev_ff, b} != sum_ff) begin
                  res_hit = 1'b1;
                  res_in.frame_kind = KIND_PUMP_SUM_BAD;
               end else if (head_ff[6] == PUMP_SRC && head_ff[7] == PUMP_CMD_STAT &&
                            len_ff >= STATUS_MIN_LEN) begin
                  // status payload starts at bus byte nine
                  res_hit = 1'b1;
                  res_in.frame_kind        = KIND_PUMP_STATUS;
                  res_in.run_code          = head_ff[9];
                  res_in.program_code      = head_ff[10];
                  res_in.power_watts       = {head_ff[12], head_ff[13]};
                  res_in.speed_rpm         = {head_ff[14], head_ff[15]};
                  res_in.flow_raw          = head_ff[16];
                  res_in.pressure_raw      = head_ff[17];
                  res_in.time_left_minutes = 14'(head_ff[20]) * MIN_PER_HOUR +
                                             14'(head_ff[21]);
                  res_in.clock_minutes     = 14'(head_ff[22]) * MIN_PER_HOUR +
                                             14'(head_ff[23]);
               end else begin
                  res_hit = 1'b1;
                  res_in.frame_kind = KIND_PUMP_OTHER;
               end
            end
         end else begin
            // chlorinator frame, decoded at its end mark
            if (chl_end) begin
               res_hit = 1'b1;
               if (n >= 9'd4 && head_ff[3] == CMD_VERSION) begin
                  res_in.frame_kind = KIND_VERSION;
               end else if (n >= 9'd4 && head_ff[3] == CMD_TEMP) begin
                  res_in.frame_kind        = KIND_TEMP;
                  res_in.water_temperature = hv4;
               end else if (n >= 9'd4 && head_ff[3] == CMD_SALT) begin
                  res_in.frame_kind  = KIND_SALT;
                  res_in.salt_ppm    = 14'(hv4) * SALT_SCALE;
                  res_in.fault_flags = hv5;
               end else if (n >= 9'd4 && head_ff[3] == CMD_TAKEOVER) begin
                  res_in.frame_kind = KIND_TAKEOVER;
               end else begin
                  res_in.frame_kind = KIND_CHLOR_OTHER;
               end
            end else if ({1'b0, n} + 10'd1 >= CHLOR_MAX_W) begin
               res_hit = 1'b1;
               res_in.frame_kind = KIND_CHLOR_OVFL;
            end else begin
               prev_in = b;
            end
         end
         if (res_hit) begin
            type_in  = FT_IDLE;
            count_in = '0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         type_ff      <= FT_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         prev_ff      <= '0;
         len_ff       <= '0;
      end else begin
         byte_vld_ff  <= byte_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (adv) begin
            type_ff  <= type_in;
            count_ff <= count_in;
            sum_ff   <= sum_in;
            prev_ff  <= prev_in;
            len_ff   <= len_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         byte_ff <= req_rx_byte;
      end
      if (adv && head_we) begin
         head_ff[head_idx] <= byte_ff;
      end
      if (adv && res_hit) begin
         res_ff <= res_in;
      end
   end

   // result ports
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_frame_kind        = res_ff.frame_kind;
   assign rsp_water_temperature = res_ff.water_temperature;
   assign rsp_salt_ppm          = res_ff.salt_ppm;
   assign rsp_fault_flags       = res_ff.fault_flags;
   assign rsp_run_code          = res_ff.run_code;
   assign rsp_program_code      = res_ff.program_code;
   assign rsp_power_watts       = res_ff.power_watts;
   assign rsp_speed_rpm         = res_ff.speed_rpm;
   assign rsp_flow_raw          = res_ff.flow_raw;
   assign rsp_pressure_raw      = res_ff.pressure_raw;
   assign rsp_time_left_minutes = res_ff.time_left_minutes;
   assign rsp_clock_minutes     = res_ff.clock_minutes;

   // idle framer holds no byte count
   assert property (@(posedge clock) disable iff (reset)
      type_ff == FT_IDLE |-> count_ff == 9'd0)
      else $error("idle framer with nonzero count");

   // pump frame never runs past length plus checksum
   assert property (@(posedge clock) disable iff (reset)
      type_ff == FT_PUMP |-> count_ff <= len_ff + 9'd10 || count_ff <= 9'd9)
      else $error("pump frame count overran its length");

   // only a status result carries pump fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_kind != KIND_PUMP_STATUS |->
         rsp_power_watts == 16'd0 && rsp_speed_rpm == 16'd0 && rsp_run_code == 8'd0)
      else $error("pump fields set on non-status result");

   // a held input byte is not lost while the result side backs up
   assert property (@(posedge clock) disable iff (reset)
      byte_vld_ff && req_stall |=> byte_vld_ff && $stable(byte_ff))
      else $error("held byte dropped");

endmodule

@@ tb/sv/tb_pool_bus_dual_frame_receiver.sv @@
module tb_pool_bus_dual_frame_receiver;
   import pbdfr_pkg::*;

   localparam int CHLOR_MAX_BYTES    = 64;
   localparam int PUMP_MAX_PAYLOAD   = 255;
   localparam int RANDOM_PHASE_BYTES = 480;
   localparam int DRAIN_CYCLES       = 8;
   localparam int CYCLE_LIMIT        = 400000;

   typedef enum logic [1:0] {FRAMER_IDLE, FRAMER_PUMP, FRAMER_CHLOR} framer_state_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [3:0]  rsp_frame_kind;
   logic [7:0]  rsp_water_temperature;
   logic [13:0] rsp_salt_ppm;
   logic [7:0]  rsp_fault_flags;
   logic [7:0]  rsp_run_code;
   logic [7:0]  rsp_program_code;
   logic [15:0] rsp_power_watts;
   logic [15:0] rsp_speed_rpm;
   logic [7:0]  rsp_flow_raw;
   logic [7:0]  rsp_pressure_raw;
   logic [13:0] rsp_time_left_minutes;
   logic [13:0] rsp_clock_minutes;

   // framer mirror: follows each accepted byte and queues the frames it decodes
   class frame_tracker_type;
      framer_state_type state;
      logic [8:0]    count;
      logic [7:0]    hdr[HEAD_DEPTH];
      logic [15:0]   run_sum;
      logic [7:0]    prev_byte;
      logic [7:0]    pay_len;
      result_type    pending_frames[$];
      int            mismatch_count;

      function new();
         state = FRAMER_IDLE;
         count = '0;
         foreach (hdr[i]) hdr[i] = '0;
         run_sum = '0;
         prev_byte = '0;
         pay_len = '0;
         mismatch_count = 0;
      endfunction

      function void close_frame(inout result_type r, input logic [3:0] kind);
         r.frame_kind = kind;
         state = FRAMER_IDLE;
         count = '0;
      endfunction

      function bit pump_byte(int n, logic [7:0] b, inout result_type r);
         // a broken lead-in drops the frame and the offending byte
         if ((n == 1 && b != PUMP_ZERO) || (n == 2 && b != PUMP_SYNC) ||
             (n == 3 && b != PUMP_LEAD)) begin
            state = FRAMER_IDLE;
            count = '0;
            return 0;
         end
         if (n >= 3 && n <= 8 + int'(pay_len)) run_sum = run_sum + b;
         if (n == 8) begin
            pay_len = b;
            if (int'(b) > PUMP_MAX_PAYLOAD) begin
               close_frame(r, KIND_PUMP_LONG);
               return 1;
            end
         end
         if (n <= 8 || n < int'(pay_len) + 10) begin
            prev_byte = b;
            return 0;
         end
         // checksum low byte has arrived
         if ({prev_byte, b} != run_sum) begin
            close_frame(r, KIND_PUMP_SUM_BAD);
            return 1;
         end
         if (hdr[6] == PUMP_SRC && hdr[7] == PUMP_CMD_STAT && pay_len >= STATUS_MIN_LEN) begin
            r.run_code          = hdr[9];
            r.program_code      = hdr[10];
            r.power_watts       = {hdr[12], hdr[13]};
            r.speed_rpm         = {hdr[14], hdr[15]};
            r.flow_raw          = hdr[16];
            r.pressure_raw      = hdr[17];
            r.time_left_minutes = hdr[20] * MIN_PER_HOUR + hdr[21];
            r.clock_minutes     = hdr[22] * MIN_PER_HOUR + hdr[23];
            close_frame(r, KIND_PUMP_STATUS);
         end else begin
            close_frame(r, KIND_PUMP_OTHER);
         end
         return 1;
      endfunction

      function bit chlor_byte(int n, logic [7:0] b, inout result_type r);
         bit at_end;
         at_end = n >= 3 && b == CHLOR_ETX && prev_byte == CHLOR_DLE && hdr[1] == CHLOR_STX;
         if (at_end) begin
            if (n >= 4 && hdr[3] == CMD_VERSION) begin
               close_frame(r, KIND_VERSION);
            end else if (n >= 4 && hdr[3] == CMD_TEMP) begin
               r.water_temperature = hdr[4];
               close_frame(r, KIND_TEMP);
            end else if (n >= 4 && hdr[3] == CMD_SALT) begin
               r.salt_ppm = hdr[4] * SALT_SCALE;
               r.fault_flags = hdr[5];
               close_frame(r, KIND_SALT);
            end else if (n >= 4 && hdr[3] == CMD_TAKEOVER) begin
               close_frame(r, KIND_TAKEOVER);
            end else begin
               close_frame(r, KIND_CHLOR_OTHER);
            end
            return 1;
         end
         if (n + 1 >= CHLOR_MAX_BYTES) begin
            close_frame(r, KIND_CHLOR_OVFL);
            return 1;
         end
         prev_byte = b;
         return 0;
      endfunction

      // returns 1 when the byte completes or rejects a frame
      function bit step_framer(logic [7:0] b, output result_type r);
         int n;
         r = '0;
         if (state == FRAMER_IDLE) begin
            if (b == PUMP_SYNC || b == CHLOR_DLE) begin
               state = (b == PUMP_SYNC) ? FRAMER_PUMP : FRAMER_CHLOR;
               hdr[0] = b;
               count = 9'd1;
               run_sum = '0;
               prev_byte = b;
               pay_len = '0;
            end
            return 0;
         end
         n = int'(count);
         if (n < HEAD_DEPTH) hdr[n] = b;
         count = count + 9'd1;
         if (state == FRAMER_PUMP) return pump_byte(n, b, r);
         return chlor_byte(n, b, r);
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $time, what);
         mismatch_count++;
      endtask

      task compare_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
      endtask

      function void note_byte(logic [7:0] b);
         result_type r;
         if (step_framer(b, r)) pending_frames.insert(pending_frames.size(), r);
      endfunction

      task check_frame(result_type got);
         result_type want;
         if (pending_frames.size() == 0) begin
            report($sformatf("unexpected item with kind %0d", got.frame_kind));
            return;
         end
         want = pending_frames.pop_front();
         compare_field("frame_kind", got.frame_kind, want.frame_kind);
         compare_field("water_temperature", got.water_temperature, want.water_temperature);
         compare_field("salt_ppm", got.salt_ppm, want.salt_ppm);
         compare_field("fault_flags", got.fault_flags, want.fault_flags);
         compare_field("run_code", got.run_code, want.run_code);
         compare_field("program_code", got.program_code, want.program_code);
         compare_field("power_watts", got.power_watts, want.power_watts);
         compare_field("speed_rpm", got.speed_rpm, want.speed_rpm);
         compare_field("flow_raw", got.flow_raw, want.flow_raw);
         compare_field("pressure_raw", got.pressure_raw, want.pressure_raw);
         compare_field("time_left_minutes", got.time_left_minutes, want.time_left_minutes);
         compare_field("clock_minutes", got.clock_minutes, want.clock_minutes);
      endtask

      task check_drained();
         if (pending_frames.size() != 0)
            report($sformatf("%0d expected items never arrived", pending_frames.size()));
      endtask
   endclass

   frame_tracker_type tracker = new();
   logic [7:0]   frame_bytes[$];
   result_type   seen_frame;
   int           bytes_sent = 0;
   int           gap_pct = 0;
   int           stall_pct = 0;
   int unsigned  cycle_count = 0;

   pool_bus_dual_frame_receiver u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_rx_byte           (req_rx_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_frame_kind        (rsp_frame_kind),
      .rsp_water_temperature (rsp_water_temperature),
      .rsp_salt_ppm          (rsp_salt_ppm),
      .rsp_fault_flags       (rsp_fault_flags),
      .rsp_run_code          (rsp_run_code),
      .rsp_program_code      (rsp_program_code),
      .rsp_power_watts       (rsp_power_watts),
      .rsp_speed_rpm         (rsp_speed_rpm),
      .rsp_flow_raw          (rsp_flow_raw),
      .rsp_pressure_raw      (rsp_pressure_raw),
      .rsp_time_left_minutes (rsp_time_left_minutes),
      .rsp_clock_minutes     (rsp_clock_minutes)
   );

   // clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // receiver backpressure
   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // watch both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) tracker.note_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall) begin
            seen_frame = '{frame_kind: rsp_frame_kind,
                           water_temperature: rsp_water_temperature,
                           salt_ppm: rsp_salt_ppm,
                           fault_flags: rsp_fault_flags,
                           run_code: rsp_run_code,
                           program_code: rsp_program_code,
                           power_watts: rsp_power_watts,
                           speed_rpm: rsp_speed_rpm,
                           flow_raw: rsp_flow_raw,
                           pressure_raw: rsp_pressure_raw,
                           time_left_minutes: rsp_time_left_minutes,
                           clock_minutes: rsp_clock_minutes};
            tracker.check_frame(seen_frame);
         end
      end
   end

   function automatic logic [7:0] pick(int fill);
      return (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
   endfunction

   // add one byte to the end of the pending frame
   function automatic void append_byte(logic [7:0] v);
      frame_bytes.insert(frame_bytes.size(), v);
   endfunction

   // pump frame with a correct or corrupted checksum
   function automatic void add_pump(int len, logic [7:0] src, logic [7:0] cmd, int fill,
                                    bit bad_sum);
      logic [15:0] total;
      logic [7:0]  v;
      append_byte(PUMP_SYNC);
      append_byte(PUMP_ZERO);
      append_byte(PUMP_SYNC);
      append_byte(PUMP_LEAD);
      total = 16'(PUMP_LEAD);
      for (int i = 4; i < 9 + len; i++) begin
         if (i == 6) v = src;
         else if (i == 7) v = cmd;
         else if (i == 8) v = 8'(len);
         else v = pick(fill);
         append_byte(v);
         total = total + v;
      end
      if (bad_sum) total = total ^ 16'(1 << $urandom_range(15));
      append_byte(total[15:8]);
      append_byte(total[7:0]);
   endfunction

   // pump lead-in cut by a wrong byte at the given index
   function automatic void add_broken(int at);
      logic [7:0] lead[4];
      logic [7:0] v;
      lead = '{PUMP_SYNC, PUMP_ZERO, PUMP_SYNC, PUMP_LEAD};
      for (int i = 0; i < at; i++) append_byte(lead[i]);
      do v = 8'($urandom_range(255)); while (v == lead[at]);
      append_byte(v);
   endfunction

   // chlorinator frame: start, address, command, data, end mark
   function automatic void add_chlor(logic [7:0] second, logic [7:0] cmd, int ndata,
                                     int fill);
      append_byte(CHLOR_DLE);
      append_byte(second);
      append_byte(pick(fill));
      append_byte(cmd);
      for (int i = 0; i < ndata; i++) append_byte(pick(fill));
      append_byte(CHLOR_DLE);
      append_byte(CHLOR_ETX);
   endfunction

   // chlorinator frame that never ends; no escape byte so no end mark appears
   function automatic void add_chlor_overflow(logic [7:0] second);
      logic [7:0] v;
      append_byte(CHLOR_DLE);
      append_byte(second);
      for (int i = 2; i < CHLOR_MAX_BYTES; i++) begin
         v = 8'($urandom_range(255));
         if (v == CHLOR_DLE) v = 8'h11;
         append_byte(v);
      end
   endfunction

   // idle noise, mostly bytes that start nothing
   function automatic void add_noise(int n);
      logic [7:0] v;
      for (int i = 0; i < n; i++) begin
         v = 8'($urandom_range(255));
         if (v == CHLOR_DLE && $urandom_range(3) != 0) v = 8'h11;
         append_byte(v);
      end
   endfunction

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
      frame_bytes.delete();
   endtask

   // mostly well-formed frames with random content, some broken ones and noise
   task automatic run_random(int count);
      int         stop_at;
      int         roll;
      logic [7:0] cmd;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) begin
         roll = $urandom_range(99);
         if (roll < 30) begin
            add_pump(($urandom_range(39) == 0) ? $urandom_range(255) : $urandom_range(20, 15),
                     PUMP_SRC, PUMP_CMD_STAT, -1, 1'b0);
         end else if (roll < 40) begin
            add_pump($urandom_range(20), pick(-1), pick(-1), -1, 1'b0);
         end else if (roll < 45) begin
            add_pump($urandom_range(14), PUMP_SRC, PUMP_CMD_STAT, -1, 1'b0);
         end else if (roll < 50) begin
            add_pump($urandom_range(20), PUMP_SRC, PUMP_CMD_STAT, -1, 1'b1);
         end else if (roll < 55) begin
            add_broken($urandom_range(3, 1));
         end else if (roll < 85) begin
            case ($urandom_range(4))
               0: cmd = CMD_VERSION;
               1: cmd = CMD_TEMP;
               2: cmd = CMD_SALT;
               3: cmd = CMD_TAKEOVER;
               default: cmd = pick(-1);
            endcase
            add_chlor(CHLOR_STX, cmd, $urandom_range(4), -1);
         end else if (roll < 90) begin
            append_byte(CHLOR_DLE);
            append_byte(CHLOR_STX);
            append_byte(CHLOR_DLE);
            append_byte(CHLOR_ETX);
         end else if (roll < 94) begin
            add_chlor_overflow(($urandom_range(1) == 0) ? CHLOR_STX : pick(-1));
         end else begin
            add_noise($urandom_range(4, 1));
         end
         send_frame();
      end
   endtask

   initial begin
      req_valid <= 1'b0;
      req_rx_byte <= 8'h00;
      rsp_stall <= 1'b0;
      reset <= 1'b1;
      gap_pct = 21;
      stall_pct = 65;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // pump status with all-zero and all-ones payloads, then the longest payload
      add_pump(15, PUMP_SRC, PUMP_CMD_STAT, 8'h00, 1'b0);
      add_pump(15, PUMP_SRC, PUMP_CMD_STAT, 8'hFF, 1'b0);
      add_pump(PUMP_MAX_PAYLOAD, PUMP_SRC, PUMP_CMD_STAT, 8'hFF, 1'b0);
      // short status payload, other frame with empty payload, bad checksum
      add_pump(14, PUMP_SRC, PUMP_CMD_STAT, -1, 1'b0);
      add_pump(0, 8'h10, 8'h01, -1, 1'b0);
      add_pump(20, PUMP_SRC, PUMP_CMD_STAT, -1, 1'b1);
      // lead-in broken at each checked position
      add_broken(1);
      add_broken(2);
      add_broken(3);
      // idle noise
      append_byte(8'h00);
      append_byte(8'h7F);
      append_byte(PUMP_LEAD);
      append_byte(CHLOR_ETX);
      // every chlorinator command, with extreme data bytes
      add_chlor(CHLOR_STX, CMD_VERSION, 0, -1);
      add_chlor(CHLOR_STX, CMD_TEMP, 1, 8'hFF);
      add_chlor(CHLOR_STX, CMD_SALT, 2, 8'hFF);
      add_chlor(CHLOR_STX, CMD_SALT, 2, 8'h00);
      add_chlor(CHLOR_STX, CMD_TAKEOVER, 0, 8'h00);
      add_chlor(CHLOR_STX, 8'h55, 1, 8'h00);
      // end mark straight after the start bytes
      append_byte(CHLOR_DLE);
      append_byte(CHLOR_STX);
      append_byte(CHLOR_DLE);
      append_byte(CHLOR_ETX);
      // overflow with a proper start and with a wrong second byte
      add_chlor_overflow(CHLOR_STX);
      add_chlor_overflow(8'h55);
      send_frame();

      run_random(RANDOM_PHASE_BYTES);
      gap_pct = 65;
      stall_pct = 21;
      run_random(RANDOM_PHASE_BYTES);
      gap_pct = 0;
      stall_pct = 0;
      run_random(RANDOM_PHASE_BYTES);
      req_valid <= 1'b0;

      // drain
      while (tracker.pending_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      tracker.check_drained();
      if (tracker.mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
